// ===== sv/hsv_to_rgb_converter_defines.svh =====
// Assertion macros for the HSV to RGB converter checks.
// Needs clk and arst_n in scope where a macro is used; no other dependencies.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HSVRGB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsvrgb check failed");

// Next-cycle implication, checked outside reset
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsvrgb check failed");

`endif

// ===== sv/hsvrgb_pkg.sv =====
// Shared types and constants of the HSV to RGB converter.
// No dependencies; used by the channel interfaces and the RTL modules.
package hsvrgb_pkg;

	localparam int HUE_W  = 16;
	localparam int SAT_W  = 17;
	localparam int BRI_W  = 17;
	localparam int BYTE_W = 8;

	// Request carried on the input channel
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [BRI_W-1:0] brightness;
	} hsv_t;

	// Request carried on the output channel
	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

	// Sixth of the color wheel that the hue falls in
	typedef enum logic [2:0] {
		SECTOR_RED_YELLOW    = 3'd0,
		SECTOR_YELLOW_GREEN  = 3'd1,
		SECTOR_GREEN_CYAN    = 3'd2,
		SECTOR_CYAN_BLUE     = 3'd3,
		SECTOR_BLUE_MAGENTA  = 3'd4,
		SECTOR_MAGENTA_RED   = 3'd5
	} sector_t;

endpackage

// ===== sv/hsvrgb_hsv_if.sv =====
// Valid/ready channel that carries HSV requests.
// Depends on hsvrgb_pkg for the payload type.
interface hsvrgb_hsv_if;
	logic               valid;
	logic               ready;
	hsvrgb_pkg::hsv_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hsvrgb_rgb_if.sv =====
// Valid/ready channel that carries RGB requests.
// Depends on hsvrgb_pkg for the payload type.
interface hsvrgb_rgb_if;
	logic               valid;
	logic               ready;
	hsvrgb_pkg::rgb_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hsvrgb_to_byte.sv =====
// Scales one channel level (fraction, 2^FRAC_BITS = 1.0) to 0..255,
// rounding half up and saturating. Depends on hsvrgb_pkg.
module hsvrgb_to_byte #(
	parameter int FRAC_BITS = 16
) (
	input  logic [FRAC_BITS:0]                level,
	output logic [hsvrgb_pkg::BYTE_W-1:0]     code
);

	localparam int LW = FRAC_BITS + 1;
	localparam int PW = LW + hsvrgb_pkg::BYTE_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	logic [PW-1:0]                   scaled;
	logic [hsvrgb_pkg::BYTE_W:0]     whole;

	// level * 255 as a shift and subtract, plus one half for rounding
	assign scaled = (PW'(level) << hsvrgb_pkg::BYTE_W) - PW'(level) + HALF;
	assign whole  = scaled[PW-1:FRAC_BITS];

	// Clip at full scale
	assign code = whole[hsvrgb_pkg::BYTE_W] ? {hsvrgb_pkg::BYTE_W{1'b1}}
		: whole[hsvrgb_pkg::BYTE_W-1:0];

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: four-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_hsv_if, hsvrgb_rgb_if and hsvrgb_to_byte.
//
//  channel  | dir | payload                          | handshake
//  ---------+-----+----------------------------------+------------
//  hsv_in   | in  | hue, saturation, brightness      | valid/ready
//  rgb_out  | out | red, green, blue                 | valid/ready
//
// One request per clock while the output does not stall; a result moves through the
// stage 1 to stage 4 registers in order and is presented from the stage 4 register.
// The depth is set by the two rows of multipliers (f*s, then v*(1-x)) plus the
// sector/scale stage and the sector split. Reset empties the pipeline; stages
// move up whenever the stage ahead is free or draining, so a stalled output
// holds every request in place.
module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	hsvrgb_hsv_if.sink       hsv_in,
	hsvrgb_rgb_if.source     rgb_out
);

	localparam int SW = FRAC_BITS + 1;
	localparam int PW = 2 * SW;
	localparam int HW = (hsvrgb_pkg::HUE_W < FRAC_BITS) ? hsvrgb_pkg::HUE_W : FRAC_BITS;
	localparam int XW = (hsvrgb_pkg::SAT_W > SW) ? hsvrgb_pkg::SAT_W : SW;
	localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// Stage advance enables
	logic adv_s1, adv_s2, adv_s3, adv_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign adv_s4 = !valid_s4 || rgb_out.ready;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign hsv_in.ready = adv_s1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= hsv_in.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: clamp s and v, split hue*6 into sector and fraction
	logic [FRAC_BITS-1:0]   hue_fx;
	logic [FRAC_BITS+2:0]   hue6;
	logic [XW-1:0]          sat_x, bri_x;
	logic [SW-1:0]          sat_cl, bri_cl;

	assign hue_fx = FRAC_BITS'(hsv_in.data.hue[HW-1:0]);
	assign hue6   = (FRAC_BITS+3)'({hue_fx, 2'b00}) + (FRAC_BITS+3)'({hue_fx, 1'b0});
	assign sat_x  = XW'(hsv_in.data.saturation);
	assign bri_x  = XW'(hsv_in.data.brightness);
	assign sat_cl = (sat_x > XW'(ONE)) ? ONE : SW'(sat_x);
	assign bri_cl = (bri_x > XW'(ONE)) ? ONE : SW'(bri_x);

	hsvrgb_pkg::sector_t    sector_s1;
	logic [FRAC_BITS-1:0]   frac_s1;
	logic [SW-1:0]          sat_s1, bri_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sector_s1 <= hsvrgb_pkg::sector_t'(hue6[FRAC_BITS+2:FRAC_BITS]);
			frac_s1   <= hue6[FRAC_BITS-1:0];
			sat_s1    <= sat_cl;
			bri_s1    <= bri_cl;
		end
	end

	// Stage 2: f*s, (1-f)*s and 1-s, products truncated back to the fraction format
	logic [PW-1:0] prod_fs, prod_gs;

	assign prod_fs = PW'(frac_s1) * PW'(sat_s1);
	assign prod_gs = PW'(ONE - SW'(frac_s1)) * PW'(sat_s1);

	hsvrgb_pkg::sector_t    sector_s2;
	logic [SW-1:0]          fs_s2, gs_s2, nots_s2, bri_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sector_s2 <= sector_s1;
			fs_s2     <= prod_fs[2*FRAC_BITS:FRAC_BITS];
			gs_s2     <= prod_gs[2*FRAC_BITS:FRAC_BITS];
			nots_s2   <= ONE - sat_s1;
			bri_s2    <= bri_s1;
		end
	end

	// Stage 3: p, q and t as v times one minus each term
	logic [PW-1:0] prod_p, prod_q, prod_t;

	assign prod_p = PW'(bri_s2) * PW'(nots_s2);
	assign prod_q = PW'(bri_s2) * PW'(ONE - fs_s2);
	assign prod_t = PW'(bri_s2) * PW'(ONE - gs_s2);

	hsvrgb_pkg::sector_t    sector_s3;
	logic [SW-1:0]          p_s3, q_s3, t_s3, bri_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sector_s3 <= sector_s2;
			p_s3      <= prod_p[2*FRAC_BITS:FRAC_BITS];
			q_s3      <= prod_q[2*FRAC_BITS:FRAC_BITS];
			t_s3      <= prod_t[2*FRAC_BITS:FRAC_BITS];
			bri_s3    <= bri_s2;
		end
	end

	// Stage 4: route v, p, q, t by sector and scale each channel
	logic [SW-1:0] red_lvl, green_lvl, blue_lvl;

	always_comb begin
		case (sector_s3)
			hsvrgb_pkg::SECTOR_RED_YELLOW: begin
				red_lvl = bri_s3; green_lvl = t_s3;   blue_lvl = p_s3;
			end
			hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
				red_lvl = q_s3;   green_lvl = bri_s3; blue_lvl = p_s3;
			end
			hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
				red_lvl = p_s3;   green_lvl = bri_s3; blue_lvl = t_s3;
			end
			hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
				red_lvl = p_s3;   green_lvl = q_s3;   blue_lvl = bri_s3;
			end
			hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
				red_lvl = t_s3;   green_lvl = p_s3;   blue_lvl = bri_s3;
			end
			default: begin
				red_lvl = bri_s3; green_lvl = p_s3;   blue_lvl = q_s3;
			end
		endcase
	end

	logic [hsvrgb_pkg::BYTE_W-1:0] red_b, green_b, blue_b;

	hsvrgb_to_byte #(.FRAC_BITS(FRAC_BITS)) u_red (.level(red_lvl), .code(red_b));
	hsvrgb_to_byte #(.FRAC_BITS(FRAC_BITS)) u_green (.level(green_lvl), .code(green_b));
	hsvrgb_to_byte #(.FRAC_BITS(FRAC_BITS)) u_blue (.level(blue_lvl), .code(blue_b));

	hsvrgb_pkg::rgb_t rgb_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			rgb_s4.red   <= red_b;
			rgb_s4.green <= green_b;
			rgb_s4.blue  <= blue_b;
		end
	end

	assign rgb_out.valid = valid_s4;
	assign rgb_out.data  = rgb_s4;

endmodule

// ===== sv/hsvrgb_checker.sv =====
// Port-level checks for hsv_to_rgb_converter, attached with a bind.
// Depends on hsv_to_rgb_converter_defines.svh and hsvrgb_pkg.
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [hsvrgb_pkg::SAT_W-1:0]    in_saturation,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [hsvrgb_pkg::BYTE_W-1:0]   out_red,
	input logic [hsvrgb_pkg::BYTE_W-1:0]   out_green,
	input logic [hsvrgb_pkg::BYTE_W-1:0]   out_blue
);

	// Hold a stalled result in place
	`HSVRGB_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid)
	`HSVRGB_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out_red) && $stable(out_green) && $stable(out_blue))

	// A request taken into a free-flowing pipeline shows up at the output
	`HSVRGB_ASSERT_NEXT(a_latency, (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

	// Zero saturation gives a gray result
	`HSVRGB_ASSERT_NEXT(a_gray, (in_valid && in_ready && out_ready && (in_saturation == '0)) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid && (out_red == out_green) && (out_green == out_blue))

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (hsv_in.valid),
	.in_ready      (hsv_in.ready),
	.in_saturation (hsv_in.data.saturation),
	.out_valid     (rgb_out.valid),
	.out_ready     (rgb_out.ready),
	.out_red       (rgb_out.data.red),
	.out_green     (rgb_out.data.green),
	.out_blue      (rgb_out.data.blue)
);
